// ===== rtl/core/sse_pkg.sv =====
`timescale 1ns / 1ps

package sse_pkg;

	// Field codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_RESP  = 1'b1;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_WORD  = 2'd1;
	localparam logic [1:0] SIZE_DWORD = 2'd2;

	localparam int unsigned ADDR_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH    = 2;

	// Input item
	typedef struct packed {
		logic        opcode;
		logic [31:0] segment_base;
		logic [31:0] dest_offset;
		logic [31:0] repeat_count;
		logic [31:0] store_value;
		logic        direction_down;
		logic        repeat_prefix;
		logic        short_addressing;
		logic [1:0]  operand_size;
		logic        write_ok;
	} cmd_t;

	// Result item
	typedef struct packed {
		logic        result_kind;
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic [1:0]  write_size;
		logic        status;
		logic [31:0] final_offset;
		logic [31:0] final_count;
		logic        count_update;
	} rsp_t;

	// Decoded item handed from front to back
	typedef struct packed {
		logic        is_resp;
		logic        ok;
		logic [31:0] base;
		logic [31:0] offset;
		logic [31:0] count;
		logic        count_zero;
		logic [31:0] data;
		logic        dir;
		logic        rep;
		logic        shrt;
		logic [1:0]  size;
	} job_t;

endpackage

// ===== rtl/core/sse_chan_if.sv =====
`timescale 1ns / 1ps

interface sse_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sse_queue.sv =====
`timescale 1ns / 1ps

module sse_queue
	import sse_pkg::*;
#(
	parameter type T = job_t,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	sse_chan_if.sink   enq,
	sse_chan_if.source deq
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	T                 entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign enq.ready = (count_q != CNT_W'(DEPTH));
	assign deq.valid = (count_q != '0);
	assign deq.data  = entries_q[rd_ptr_q];
	assign push      = enq.valid && enq.ready;
	assign pop       = deq.valid && deq.ready;

	// Store entry on an input transfer
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= enq.data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/core/sse_front.sv =====
`timescale 1ns / 1ps

module sse_front
	import sse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sse_chan_if.sink   cmd,
	sse_chan_if.source job
);
	sse_chan_if #(.T(job_t)) dec_ch ();

	logic [1:0]  size_n;
	logic [31:0] count_n;

	// Normalize operand size: code three acts as dword
	assign size_n = (cmd.data.operand_size == SIZE_BYTE || cmd.data.operand_size == SIZE_WORD)
		? cmd.data.operand_size : SIZE_DWORD;

	// Count: one without the prefix, 16 bits under short addressing
	always_comb begin
		if (!cmd.data.repeat_prefix) begin
			count_n = 32'd1;
		end else if (cmd.data.short_addressing) begin
			count_n = {16'd0, cmd.data.repeat_count[15:0]};
		end else begin
			count_n = cmd.data.repeat_count;
		end
	end

	// Classify and decode the item
	always_comb begin
		dec_ch.data.is_resp    = (cmd.data.opcode == OP_RESP);
		dec_ch.data.ok         = cmd.data.write_ok;
		dec_ch.data.base       = cmd.data.segment_base;
		dec_ch.data.offset     = cmd.data.short_addressing
			? {16'd0, cmd.data.dest_offset[15:0]} : cmd.data.dest_offset;
		dec_ch.data.count      = count_n;
		dec_ch.data.count_zero = (count_n == '0);
		dec_ch.data.dir        = cmd.data.direction_down;
		dec_ch.data.rep        = cmd.data.repeat_prefix;
		dec_ch.data.shrt       = cmd.data.short_addressing;
		dec_ch.data.size       = size_n;
		unique case (size_n)
			SIZE_BYTE: dec_ch.data.data = {24'd0, cmd.data.store_value[7:0]};
			SIZE_WORD: dec_ch.data.data = {16'd0, cmd.data.store_value[15:0]};
			default:   dec_ch.data.data = cmd.data.store_value;
		endcase
	end

	assign dec_ch.valid = cmd.valid;
	assign cmd.ready    = dec_ch.ready;

	sse_queue #(
		.T     (job_t),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.enq    (dec_ch.sink),
		.deq    (job)
	);
endmodule

// ===== rtl/core/sse_back.sv =====
`timescale 1ns / 1ps

module sse_back
	import sse_pkg::*;
#(
	parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sse_chan_if.sink   job,
	sse_chan_if.source rsp
);
	localparam logic [ADDR_WIDTH-1:0] SHORT_MASK = ADDR_WIDTH'(17'h0FFFF);

	logic                  busy_q;
	logic [ADDR_WIDTH-1:0] offset_q;
	logic [31:0]           remaining_q;
	logic [31:0]           base_q;
	logic [31:0]           value_q;
	logic                  dir_q;
	logic                  rep_q;
	logic                  shrt_q;
	logic [1:0]            size_q;

	logic                  out_valid_q;
	rsp_t                  out_q;

	logic                  pop;
	logic                  emit;
	rsp_t                  res;
	logic [ADDR_WIDTH-1:0] step;
	logic [ADDR_WIDTH-1:0] next_raw;
	logic [ADDR_WIDTH-1:0] next_off;
	logic [ADDR_WIDTH-1:0] start_off;
	logic                  last_step;

	assign pop       = job.valid && (!out_valid_q || rsp.ready);
	assign job.ready = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Offset step and wrap
	always_comb begin
		unique case (size_q)
			SIZE_BYTE: step = ADDR_WIDTH'(3'd1);
			SIZE_WORD: step = ADDR_WIDTH'(3'd2);
			default:   step = ADDR_WIDTH'(3'd4);
		endcase
		next_raw = dir_q ? offset_q - step : offset_q + step;
		next_off = shrt_q ? (next_raw & SHORT_MASK) : next_raw;
	end

	assign start_off = job.data.offset[ADDR_WIDTH-1:0];
	assign last_step = (remaining_q == 32'd1);

	// Build the result for the item at the head of the queue
	always_comb begin
		emit = 1'b0;
		res  = '0;
		if (!job.data.is_resp) begin
			emit = 1'b1;
			if (job.data.count_zero) begin
				res.result_kind  = KIND_FINISH;
				res.status       = STATUS_OK;
				res.final_offset = 32'(start_off);
				res.count_update = job.data.rep;
			end else begin
				res.result_kind   = KIND_WRITE;
				res.write_address = job.data.base + 32'(start_off);
				res.write_data    = job.data.data;
				res.write_size    = job.data.size;
			end
		end else if (busy_q) begin
			emit = 1'b1;
			if (!job.data.ok) begin
				res.result_kind = KIND_FINISH;
				res.status      = STATUS_ERR;
			end else if (last_step) begin
				res.result_kind  = KIND_FINISH;
				res.status       = STATUS_OK;
				res.final_offset = 32'(next_off);
				res.count_update = rep_q;
			end else begin
				res.result_kind   = KIND_WRITE;
				res.write_address = base_q + 32'(next_off);
				res.write_data    = value_q;
				res.write_size    = size_q;
			end
		end
	end

	// Instruction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			if (!job.data.is_resp) begin
				busy_q <= !job.data.count_zero;
			end else if (busy_q && (!job.data.ok || last_step)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Latch operands on start, advance offset and count on an ok response
	always_ff @(posedge clk) begin
		if (pop) begin
			if (!job.data.is_resp) begin
				offset_q    <= start_off;
				remaining_q <= job.data.count;
				base_q      <= job.data.base;
				value_q     <= job.data.data;
				dir_q       <= job.data.dir;
				rep_q       <= job.data.rep;
				shrt_q      <= job.data.shrt;
				size_q      <= job.data.size;
			end else if (busy_q && job.data.ok) begin
				offset_q    <= next_off;
				remaining_q <= remaining_q - 32'd1;
			end
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q <= res;
		end
	end
endmodule

// ===== rtl/core/string_store_repeat_engine.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload  Role
// cmd      in   cmd_t    start items and write responses
// rsp      out  rsp_t    write requests and finish reports
//
// One item is taken per cycle while the queue has room. Its result, if any, is
// registered: the accepting edge writes the queue entry, and a later edge loads
// the output register of the execute stage once the entry is at the head and
// that register is free. The execute stage settles one item per cycle while its
// output register is free or taken: one offset add and one address add per step.
// Reset empties the queue and the output register and leaves no instruction running.
// Either side may stall: a two-entry queue parts decode from execute.

module string_store_repeat_engine
	import sse_pkg::*;
#(
	parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sse_chan_if.sink   cmd,
	sse_chan_if.source rsp
);
	sse_chan_if #(.T(job_t)) job_ch ();

	sse_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.job    (job_ch.source)
	);

	sse_back #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job_ch.sink),
		.rsp    (rsp)
	);
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import sse_pkg::*;

	// operand size code outside the defined set; the block treats it as dword
	localparam logic [1:0] SIZE_RSVD = 2'd3;
	localparam int unsigned N_ITEMS = 700;
	localparam int unsigned STALL_CYCLES = 80;

	// Expected-result tracker for STOS / REP STOS
	class stos_tracker;
		rsp_t pending_rsp[$];
		int unsigned mismatches = 0;
		int unsigned n_effective = 0;
		int unsigned n_starts = 0;
		int unsigned n_resps = 0;
		int unsigned n_zero = 0;
		int unsigned n_writes = 0;
		int unsigned n_finishes = 0;
		int unsigned n_errs = 0;

		logic        busy = 1'b0;
		logic [31:0] cur_off = '0;
		logic [31:0] remaining = '0;
		logic [31:0] base = '0;
		logic [31:0] value = '0;
		logic        dir = 1'b0;
		logic        rep = 1'b0;
		logic        shrt = 1'b0;
		logic [1:0]  size = SIZE_BYTE;

		function logic [31:0] off_mask(logic s);
			return s ? 32'h0000_FFFF : 32'((64'd1 << ADDR_WIDTH_DEF) - 64'd1);
		endfunction

		function void push_write();
			rsp_t r;
			r = '0;
			r.result_kind   = KIND_WRITE;
			r.write_address = base + cur_off;
			r.write_data    = (size == SIZE_BYTE) ? (value & 32'h0000_00FF) :
				(size == SIZE_WORD) ? (value & 32'h0000_FFFF) : value;
			r.write_size    = size;
			pending_rsp.push_back(r);
		endfunction

		function void push_finish(logic st);
			rsp_t r;
			r = '0;
			r.result_kind = KIND_FINISH;
			r.status      = st;
			if (st == STATUS_OK) begin
				r.final_offset = cur_off;
				r.final_count  = '0;
				r.count_update = rep;
			end
			busy = 1'b0;
			pending_rsp.push_back(r);
		endfunction

		// Advance the engine state by one accepted transfer
		function void take_cmd(cmd_t c);
			logic [31:0] step;
			if (c.opcode == OP_START) begin
				n_effective++;
				n_starts++;
				dir   = c.direction_down;
				rep   = c.repeat_prefix;
				shrt  = c.short_addressing;
				size  = (c.operand_size == SIZE_RSVD) ? SIZE_DWORD : c.operand_size;
				base  = c.segment_base;
				value = c.store_value;
				cur_off = c.dest_offset & off_mask(shrt);
				remaining = rep ? (c.repeat_count & (shrt ? 32'h0000_FFFF : 32'hFFFF_FFFF))
					: 32'd1;
				if (remaining == 0) begin
					n_zero++;
					push_finish(STATUS_OK);
				end else begin
					busy = 1'b1;
					push_write();
				end
			end else if (busy) begin
				n_effective++;
				n_resps++;
				if (!c.write_ok) begin
					push_finish(STATUS_ERR);
				end else begin
					step = (size == SIZE_BYTE) ? 32'd1 : (size == SIZE_WORD) ? 32'd2 : 32'd4;
					cur_off = dir ? cur_off - step : cur_off + step;
					cur_off &= off_mask(shrt);
					remaining = remaining - 32'd1;
					if (remaining == 0)
						push_finish(STATUS_OK);
					else
						push_write();
				end
			end
		endfunction

		function void cmp(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_rsp(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: kind %0d addr %h", got.result_kind, got.write_address);
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				if (want.result_kind == KIND_WRITE)
					n_writes++;
				else begin
					n_finishes++;
					if (want.status == STATUS_ERR)
						n_errs++;
				end
				cmp("result_kind", 32'(want.result_kind), 32'(got.result_kind));
				cmp("write_address", want.write_address, got.write_address);
				cmp("write_data", want.write_data, got.write_data);
				cmp("write_size", 32'(want.write_size), 32'(got.write_size));
				cmp("status", 32'(want.status), 32'(got.status));
				cmp("final_offset", want.final_offset, got.final_offset);
				cmp("final_count", want.final_count, got.final_count);
				cmp("count_update", 32'(want.count_update), 32'(got.count_update));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sse_chan_if #(.T(cmd_t)) cmd_if ();
	sse_chan_if #(.T(rsp_t)) rsp_if ();

	string_store_repeat_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	stos_tracker tracker = new();

	bit gaps_on = 1'b1;
	bit stall_req = 1'b0;
	int unsigned stall_left = 0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Global watchdog
	initial begin
		#3_000_000;
		$display("tb failed");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_if.ready <= 1'b0;
		end else if (stall_req) begin
			stall_req = 1'b0;
			stall_left = STALL_CYCLES;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= !(gaps_on && $urandom_range(0, 99) < 26);
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			tracker.check_rsp(rsp_if.data);
	end

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.opcode           = 1'($urandom_range(0, 1));
		c.segment_base     = $urandom;
		c.dest_offset      = $urandom;
		c.repeat_count     = $urandom;
		c.store_value      = $urandom;
		c.direction_down   = 1'($urandom_range(0, 1));
		c.repeat_prefix    = 1'($urandom_range(0, 1));
		c.short_addressing = 1'($urandom_range(0, 1));
		c.operand_size     = 2'($urandom_range(0, 3));
		c.write_ok         = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Offer one item and hold it until the transfer
	task automatic send(input cmd_t c);
		while (gaps_on && $urandom_range(0, 99) < 26) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= c;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		tracker.take_cmd(c);
		@(negedge clk);
	endtask

	task automatic send_resp(input logic ok);
		cmd_t c;
		c = rand_cmd();
		c.opcode   = OP_RESP;
		c.write_ok = ok;
		send(c);
	endtask

	task automatic send_start(input logic [31:0] seg, input logic [31:0] off,
		input logic [31:0] cnt, input logic dn, input logic rp, input logic sh,
		input logic [1:0] sz);
		cmd_t c;
		c = rand_cmd();
		c.opcode           = OP_START;
		c.segment_base     = seg;
		c.dest_offset      = off;
		c.repeat_count     = cnt;
		c.direction_down   = dn;
		c.repeat_prefix    = rp;
		c.short_addressing = sh;
		c.operand_size     = sz;
		send(c);
	endtask

	// One instruction with random content: start, then its responses
	task automatic run_instr();
		cmd_t c;
		int unsigned n;
		int unsigned k;
		int unsigned fail_at;
		c = rand_cmd();
		c.opcode           = OP_START;
		c.repeat_prefix    = ($urandom_range(0, 9) < 7);
		c.short_addressing = ($urandom_range(0, 9) < 3);
		if ($urandom_range(0, 9) != 0)
			c.repeat_count = $urandom_range(0, 6);
		case ($urandom_range(0, 7))
			0: c.dest_offset = 32'hFFFF_FFFF - $urandom_range(0, 6);
			1: c.dest_offset[15:0] = 16'hFFFF - 16'($urandom_range(0, 6));
			2: c.dest_offset[15:0] = 16'($urandom_range(0, 6));
			default: ;
		endcase
		send(c);
		if (!c.repeat_prefix)
			n = 1;
		else
			n = c.short_addressing ? {16'd0, c.repeat_count[15:0]} : c.repeat_count;
		k = (n > 12) ? $urandom_range(2, 12) : n;
		// cut some short so the next start lands mid-instruction
		if (n > 1 && $urandom_range(0, 14) == 0)
			k = $urandom_range(1, n - 1);
		fail_at = (k > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(1, k) : 0;
		for (int i = 1; i <= k; i++) begin
			send_resp(i != fail_at);
			if (i == fail_at)
				break;
		end
		// stray response
		if ($urandom_range(0, 19) == 0)
			send_resp(1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.data  = '0;
		rsp_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: response while idle
		send_resp(1'b1);
		// single byte store, address wraps at 32 bits
		send_start(32'hFFFF_FFFF, 32'h0000_0001, $urandom, 1'b0, 1'b0, 1'b0, SIZE_BYTE);
		send_resp(1'b1);
		// repeat with zero count, full and short addressing
		send_start($urandom, $urandom, 32'h0, 1'b0, 1'b1, 1'b0, SIZE_WORD);
		send_start($urandom, 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b1, 1'b1, SIZE_DWORD);
		// short addressing: offset wraps below zero at 16 bits
		send_start($urandom, 32'h1234_0002, 32'h0001_0002, 1'b1, 1'b1, 1'b1, SIZE_DWORD);
		send_resp(1'b1);
		send_resp(1'b1);
		// offset wraps at the top, then a write error
		send_start(32'h0, 32'hFFFF_FFFF, 32'd3, 1'b0, 1'b1, 1'b0, SIZE_WORD);
		send_resp(1'b1);
		send_resp(1'b0);
		// operand size three, abandoned by a new start; offset wraps below zero
		send_start($urandom, $urandom, 32'd5, 1'b0, 1'b1, 1'b0, SIZE_RSVD);
		send_resp(1'b1);
		send_start($urandom, 32'h0, $urandom, 1'b1, 1'b0, 1'b0, SIZE_BYTE);
		send_resp(1'b1);
		// largest count, then an error
		send_start(32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, SIZE_WORD);
		send_resp(1'b1);
		send_resp(1'b0);
		send_resp(1'b0);

		// Random with gaps on both sides
		while (tracker.n_effective < 250)
			run_instr();

		// Long receiver hold-off while the sender keeps offering
		gaps_on = 1'b0;
		stall_req = 1'b1;
		send_start($urandom, $urandom, 32'd60, 1'($urandom_range(0, 1)), 1'b1, 1'b0,
			2'($urandom_range(0, 3)));
		repeat (59)
			send_resp(1'b1);

		// Stretch with no idling at all
		while (tracker.n_effective < 450)
			run_instr();
		gaps_on = 1'b1;

		while (tracker.n_effective < N_ITEMS)
			run_instr();
		cmd_if.valid <= 1'b0;

		// Drain
		while (tracker.pending_rsp.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d starts (%0d zero-count repeats) and %0d live responses",
			tracker.n_starts, tracker.n_zero, tracker.n_resps);
		$display("Checked %0d write requests and %0d finish reports (%0d write errors)",
			tracker.n_writes, tracker.n_finishes, tracker.n_errs);
		if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
